### rtl/core/swos_pkg.sv
// Shared types and constants for the scan window obstacle stop block.
`default_nettype none
package swos_pkg;

  localparam int MAX_SAMPLES = 1024;

  localparam logic [1:0] MODE_FORWARD  = 2'd0;
  localparam logic [1:0] MODE_SLOWDOWN = 2'd1;
  localparam logic [1:0] MODE_STOP     = 2'd2;
  localparam logic [1:0] PEND_NONE     = 2'd0;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [2:0] CFG_STOP_DIST = 3'd0;
  localparam logic [2:0] CFG_SLOW_DIST = 3'd1;
  localparam logic [2:0] CFG_CENTER    = 3'd2;
  localparam logic [2:0] CFG_STOP_HW   = 3'd3;
  localparam logic [2:0] CFG_SLOW_HW   = 3'd4;
  localparam logic [2:0] CFG_VEL_MAX   = 3'd5;
  localparam logic [2:0] CFG_VEL_MIN   = 3'd6;
  localparam logic [2:0] CFG_VEL_STEP  = 3'd7;

  localparam logic [15:0] RST_STOP_DIST = 16'd1000;
  localparam logic [15:0] RST_SLOW_DIST = 16'd2500;
  localparam logic [9:0]  RST_CENTER    = 10'd512;
  localparam logic [9:0]  RST_STOP_HW   = 10'd64;
  localparam logic [9:0]  RST_SLOW_HW   = 10'd32;
  localparam logic [19:0] RST_VEL_MAX   = 20'd100000;
  localparam logic [19:0] RST_VEL_MIN   = 20'd10000;
  localparam logic [19:0] RST_VEL_STEP  = 20'd2250;

  typedef struct packed {
    logic        operation;
    logic [9:0]  sample_index;
    logic [15:0] range_mm;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [19:0] velocity_cmd;
    logic [1:0]  drive_mode;
    logic        config_fault;
  } out_item_t;

  typedef struct packed {
    logic [15:0] stop_distance_mm;
    logic [15:0] slow_distance_mm;
    logic [9:0]  center_index;
    logic [9:0]  stop_half_width;
    logic [9:0]  slow_half_width;
    logic [19:0] velocity_max;
    logic [19:0] velocity_min;
    logic [19:0] velocity_step;
  } cfg_regs_t;

  typedef struct packed {
    logic       is_tick;
    logic [1:0] verdict;
    logic       last;
  } q_entry_t;

  typedef struct packed {
    logic [1:0] pending;
    logic [1:0] mode;
    logic       pop;
    logic       pop_last;
  } bk_status_t;

endpackage
`default_nettype wire

### rtl/core/swos_front.sv
// Front end: accepts requests and classifies each sample against the windows.
`default_nettype none
module swos_front (
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire swos_pkg::in_item_t   in_data,
  input  wire swos_pkg::cfg_regs_t  cfg,
  input  wire logic                 q_full,
  output logic                      q_push,
  output swos_pkg::q_entry_t        q_wdata
);
  import swos_pkg::*;

  logic [9:0] idx_offset;
  logic       idx_ok;
  logic       in_stop_win;
  logic       in_slow_win;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    idx_offset = (in_data.sample_index >= cfg.center_index) ?
                 (in_data.sample_index - cfg.center_index) :
                 (cfg.center_index - in_data.sample_index);
    idx_ok      = 32'(in_data.sample_index) < MAX_SAMPLES;
    in_stop_win = idx_offset <= cfg.stop_half_width;
    in_slow_win = idx_offset <= cfg.slow_half_width;

    q_wdata.is_tick = (in_data.operation == OP_TICK);
    q_wdata.last    = in_data.last_sample;
    q_wdata.verdict = PEND_NONE;
    if (idx_ok && in_stop_win) begin
      if (in_data.range_mm < cfg.stop_distance_mm) begin
        q_wdata.verdict = MODE_STOP;
      end else if (in_slow_win && (in_data.range_mm < cfg.slow_distance_mm)) begin
        q_wdata.verdict = MODE_SLOWDOWN;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/swos_queue.sv
// Short register queue between the front end and the back end.
`default_nettype none
module swos_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire swos_pkg::q_entry_t  wdata,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output swos_pkg::q_entry_t       rdata
);
  import swos_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slots_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r,  count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign rdata     = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/core/swos_back.sv
// Back end: holds the scan decision, commits the mode and ramps the velocity.
`default_nettype none
module swos_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire swos_pkg::cfg_regs_t  cfg,
  input  wire logic                 q_not_empty,
  input  wire swos_pkg::q_entry_t   q_rdata,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output swos_pkg::out_item_t       out_data,
  output swos_pkg::bk_status_t      status
);
  import swos_pkg::*;

  logic [1:0]  mode_r,    mode_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [19:0] vel_r,     vel_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r;

  logic        out_free;
  logic        fault;
  logic [1:0]  pend_upd;
  logic [20:0] vel_up;
  logic [20:0] vel_dn;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = q_not_empty && (!q_rdata.is_tick || out_free);
  assign fault     = cfg.stop_distance_mm > cfg.slow_distance_mm;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.pending  = pending_r;
  assign status.mode     = mode_r;
  assign status.pop      = q_pop && !q_rdata.is_tick;
  assign status.pop_last = q_rdata.last;

  always_comb begin
    mode_nxt      = mode_r;
    pending_nxt   = pending_r;
    vel_nxt       = vel_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    pend_upd      = (pending_r == PEND_NONE) ? q_rdata.verdict : pending_r;
    vel_up        = {1'b0, vel_r} + {1'b0, cfg.velocity_step};
    vel_dn        = {1'b0, vel_r} - {1'b0, cfg.velocity_step};

    if (q_pop && !q_rdata.is_tick) begin
      if (q_rdata.last) begin
        if (fault) begin
          mode_nxt = MODE_STOP;
        end else if (pend_upd == PEND_NONE) begin
          mode_nxt = MODE_FORWARD;
        end else begin
          mode_nxt = pend_upd;
        end
        pending_nxt = PEND_NONE;
      end else begin
        pending_nxt = pend_upd;
      end
    end

    if (q_pop && q_rdata.is_tick) begin
      case (mode_r)
        MODE_FORWARD: begin
          vel_nxt = (vel_up < {1'b0, cfg.velocity_max}) ? vel_up[19:0] : cfg.velocity_max;
        end
        MODE_SLOWDOWN: begin
          vel_nxt = (!vel_dn[20] && (vel_dn[19:0] > cfg.velocity_min)) ?
                    vel_dn[19:0] : cfg.velocity_min;
        end
        default: begin
          vel_nxt = '0;
        end
      endcase
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FORWARD;
      pending_r   <= PEND_NONE;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      pending_r   <= pending_nxt;
      vel_r       <= vel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_rdata.is_tick) begin
      out_data_r.velocity_cmd <= vel_nxt;
      out_data_r.drive_mode   <= mode_r;
      out_data_r.config_fault <= fault;
    end
  end

endmodule
`default_nettype wire

### rtl/core/scan_window_obstacle_stop.sv
// Top level: obstacle stop controller driven by laser scan samples and control ticks.
//
// Input channel (in_valid/in_ready/in_data) carries one request per cycle while
// in_ready is high: a range sample (operation 0) or a control tick (operation 1).
// Samples give no result; each tick gives one result on the output channel
// (out_valid/out_ready/out_data): ramped velocity, drive mode, configuration fault.
// An accepted tick is written into the queue, then popped by the back end, which
// registers the result behind out_valid. Throughput: one request per cycle while
// the queue has room; the front end classifies a sample in the accept cycle and the
// back end retires one queued request per cycle unless a tick waits on the output.
// Configuration port (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
// write it only while no request is in flight.
// Reset: registers return to their defaults, mode is forward, velocity zero,
// no decision pending, queue and output empty.
// Receiver stall: the result stays in the output register; a tick at the queue
// head waits with everything behind it, and in_ready drops once the queue of
// QUEUE_DEPTH entries fills.
`default_nettype none
module scan_window_obstacle_stop #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire swos_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output swos_pkg::out_item_t       out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [19:0]          cfg_data
);
  import swos_pkg::*;

  cfg_regs_t  cfg_r, cfg_nxt;
  logic       q_full, q_push, q_pop, q_not_empty;
  q_entry_t   q_wdata, q_rdata;
  bk_status_t bk_status;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_STOP_DIST: cfg_nxt.stop_distance_mm = cfg_data[15:0];
        CFG_SLOW_DIST: cfg_nxt.slow_distance_mm = cfg_data[15:0];
        CFG_CENTER:    cfg_nxt.center_index     = cfg_data[9:0];
        CFG_STOP_HW:   cfg_nxt.stop_half_width  = cfg_data[9:0];
        CFG_SLOW_HW:   cfg_nxt.slow_half_width  = cfg_data[9:0];
        CFG_VEL_MAX:   cfg_nxt.velocity_max     = cfg_data;
        CFG_VEL_MIN:   cfg_nxt.velocity_min     = cfg_data;
        CFG_VEL_STEP:  cfg_nxt.velocity_step    = cfg_data;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_distance_mm <= RST_STOP_DIST;
      cfg_r.slow_distance_mm <= RST_SLOW_DIST;
      cfg_r.center_index     <= RST_CENTER;
      cfg_r.stop_half_width  <= RST_STOP_HW;
      cfg_r.slow_half_width  <= RST_SLOW_HW;
      cfg_r.velocity_max     <= RST_VEL_MAX;
      cfg_r.velocity_min     <= RST_VEL_MIN;
      cfg_r.velocity_step    <= RST_VEL_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  swos_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  swos_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rdata     (q_rdata)
  );

  swos_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .status      (bk_status)
  );

  a_stop_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.drive_mode == MODE_STOP)) |-> (out_data.velocity_cmd == '0))
    else $error("stop result carries nonzero velocity");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.drive_mode == MODE_FORWARD) ||
                   (out_data.drive_mode == MODE_SLOWDOWN) ||
                   (out_data.drive_mode == MODE_STOP)))
    else $error("illegal drive mode on result");

  a_pending_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_status.pop && !bk_status.pop_last && (bk_status.pending != PEND_NONE))
      |=> (bk_status.pending == $past(bk_status.pending)))
    else $error("pending decision overwritten within a scan");

  a_commit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (bk_status.pop && bk_status.pop_last) |=> (bk_status.pending == PEND_NONE))
    else $error("pending decision not cleared at end of scan");

endmodule
`default_nettype wire
